// ===== rtl/tts_pkg.sv =====
package tts_pkg;

   localparam logic [1:0] CMD_TICK     = 2'd0;
   localparam logic [1:0] CMD_ADD      = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic [1:0]  command_type;
   typedef logic [15:0] interval_type;
   typedef logic [1:0]  status_type;
   typedef logic [2:0]  task_index_type;

endpackage

// ===== rtl/tts_req_if.sv =====
interface tts_req_if;
   import tts_pkg::*;

   logic         valid;
   logic         ready;
   command_type  command;
   interval_type interval;
   logic         periodic;

   modport source (output valid, output command, output interval, output periodic,
                   input ready);
   modport sink   (input valid, input command, input interval, input periodic,
                   output ready);
endinterface

// ===== rtl/tts_rsp_if.sv =====
interface tts_rsp_if;
   import tts_pkg::*;

   logic           valid;
   logic           ready;
   status_type     status;
   task_index_type task_index;
   logic           dispatched;

   modport source (output valid, output status, output task_index, output dispatched,
                   input ready);
   modport sink   (input valid, input status, input task_index, input dispatched,
                   output ready);
endinterface

// ===== rtl/tick_task_scheduler.sv =====
// channel   dir  payload                          handshake
// req_if    in   command, interval, periodic      valid/ready
// rsp_if    out  status, task_index, dispatched   valid/ready
//
// add and unused commands: the finish state loads the result, and ready returns with it
// tick and dispatch walk the live slots through the slot memory, one read
// port and one write port, one slot a cycle
// reset clears the live count and control; slot memory needs no clearing
// a result waits in the output register while the next item is accepted;
// a finished item holds its result until the output register frees
module tick_task_scheduler #(
   parameter int SLOTS        = 8,
   parameter int PENDING_BITS = 8
) (
   input logic      clock,
   input logic      reset,
   tts_req_if.sink   req_if,
   tts_rsp_if.source rsp_if
);
   import tts_pkg::*;

   localparam int LIVE_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   typedef struct packed {
      logic [15:0]             interval;
      logic [15:0]             countdown;
      logic                    periodic;
      logic                    done;
      logic [PENDING_BITS-1:0] pending;
   } slot_rec_type;

   slot_rec_type slot_mem [SLOTS];

   logic [1:0]        state_ff, state_in;
   command_type       cmd_ff, cmd_in;
   logic [LIVE_W-1:0] live_ff, live_in;
   logic [LIVE_W-1:0] issue_ff, issue_in;
   logic              proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]  proc_idx_ff, proc_idx_in;
   slot_rec_type      rd_data_ff;
   status_type        res_status_ff, res_status_in;
   logic [IDX_W-1:0]  res_index_ff, res_index_in;
   logic              res_disp_ff, res_disp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   task_index_type    rsp_index_ff, rsp_index_in;
   logic              rsp_disp_ff, rsp_disp_in;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   slot_rec_type      mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;

   logic              req_take;
   logic              rsp_free;
   slot_rec_type      tick_rec;
   logic [15:0]       cd_dec;
   logic              pend_full;
   logic [IDX_W+2:0]  res_index_wide;

   assign req_take       = req_if.valid && req_if.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready   = (state_ff == S_IDLE);
   assign res_index_wide = {3'b000, res_index_ff};

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.task_index = rsp_index_ff;
   assign rsp_if.dispatched = rsp_disp_ff;

   // per slot tick update
   always_comb begin
      tick_rec  = rd_data_ff;
      cd_dec    = rd_data_ff.countdown - 16'd1;
      pend_full = &rd_data_ff.pending;
      if (rd_data_ff.periodic) begin
         if (cd_dec == 16'd0) begin
            tick_rec.countdown = rd_data_ff.interval;
            if (!pend_full) begin
               tick_rec.pending = rd_data_ff.pending + PENDING_BITS'(1);
            end
         end else begin
            tick_rec.countdown = cd_dec;
         end
      end else if (!rd_data_ff.done) begin
         if (rd_data_ff.countdown != 16'd0) begin
            tick_rec.countdown = cd_dec;
         end else begin
            tick_rec.done = 1'b1;
            if (!pend_full) begin
               tick_rec.pending = rd_data_ff.pending + PENDING_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      live_in       = live_ff;
      issue_in      = issue_ff;
      proc_valid_in = 1'b0;
      proc_idx_in   = proc_idx_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_disp_in   = res_disp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_disp_in   = rsp_disp_ff;
      mem_we        = 1'b0;
      mem_waddr     = proc_idx_ff;
      mem_wdata     = tick_rec;
      mem_re        = 1'b0;
      mem_raddr     = issue_ff[IDX_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in        = req_if.command;
               issue_in      = '0;
               res_status_in = ST_OK;
               res_index_in  = '0;
               res_disp_in   = 1'b0;
               state_in      = S_FINISH;
               unique case (req_if.command)
                  CMD_TICK: begin
                     state_in = S_SCAN;
                  end
                  CMD_DISPATCH: begin
                     res_status_in = ST_EMPTY;
                     state_in      = S_SCAN;
                  end
                  CMD_ADD: begin
                     if (live_ff == LIVE_W'(SLOTS)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        mem_we              = 1'b1;
                        mem_waddr           = live_ff[IDX_W-1:0];
                        mem_wdata.interval  = req_if.interval;
                        mem_wdata.countdown = req_if.interval;
                        mem_wdata.periodic  = req_if.periodic;
                        mem_wdata.done      = 1'b0;
                        mem_wdata.pending   = '0;
                        res_index_in        = live_ff[IDX_W-1:0];
                        live_in             = live_ff + LIVE_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (issue_ff < live_ff) begin
               mem_re        = 1'b1;
               proc_valid_in = 1'b1;
               proc_idx_in   = issue_ff[IDX_W-1:0];
               issue_in      = issue_ff + LIVE_W'(1);
            end
            if (proc_valid_ff) begin
               if (cmd_ff == CMD_TICK) begin
                  mem_we = 1'b1;
               end else if (rd_data_ff.pending != '0) begin
                  mem_we            = 1'b1;
                  mem_wdata         = rd_data_ff;
                  mem_wdata.pending = rd_data_ff.pending - PENDING_BITS'(1);
                  res_status_in     = ST_OK;
                  res_index_in      = proc_idx_ff;
                  res_disp_in       = 1'b1;
                  proc_valid_in     = 1'b0;
                  mem_re            = 1'b0;
                  state_in          = S_FINISH;
               end
            end else if (!(issue_ff < live_ff)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_wide[2:0];
               rsp_disp_in   = res_disp_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         proc_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         proc_valid_ff <= proc_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      issue_ff      <= issue_in;
      proc_idx_ff   <= proc_idx_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_disp_ff   <= res_disp_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_disp_ff   <= rsp_disp_in;
   end

`ifndef SYNTH
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= LIVE_W'(SLOTS))
      else $error("live slot count beyond table size");

   a_disp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.dispatched |-> rsp_if.status == ST_OK)
      else $error("dispatched item without ok status");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_if.ready)
      else $error("ready again right after taking an item");

   a_scan_valid: assert property (@(posedge clock) disable iff (reset)
      proc_valid_ff |-> state_ff == S_SCAN)
      else $error("slot read data outside of a walk");
`endif

endmodule

// ===== dv/tts_checker.sv =====
module tts_checker #(
   parameter int SLOTS        = 8,
   parameter int PENDING_BITS = 8
) (
   input  logic clock,
   input  logic reset,
   tts_req_if   req_if,
   tts_rsp_if   rsp_if,
   output int   fail_count,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import tts_pkg::*;

   typedef struct packed {
      status_type     status;
      task_index_type task_index;
      logic           dispatched;
   } reply_type;

   localparam logic [PENDING_BITS-1:0] RUNS_MAX = '1;

   interval_type            tbl_interval  [SLOTS];
   interval_type            tbl_countdown [SLOTS];
   logic                    tbl_periodic  [SLOTS];
   logic                    tbl_done      [SLOTS];
   logic [PENDING_BITS-1:0] tbl_runs      [SLOTS];
   int                      tbl_live;

   reply_type owed_replies[$];

   task automatic post_run(input int s);
      if (tbl_runs[s] != RUNS_MAX) tbl_runs[s] = tbl_runs[s] + 1'b1;
   endtask

   task automatic predict_reply(input command_type cmd, input interval_type intv,
                                input logic per, output reply_type r);
      int   s;
      logic found;
      r.status     = ST_OK;
      r.task_index = '0;
      r.dispatched = 1'b0;
      found        = 1'b0;
      case (cmd)
         CMD_TICK: begin
            for (s = 0; s < tbl_live; s++) begin
               if (tbl_periodic[s]) begin
                  tbl_countdown[s] = tbl_countdown[s] - 1'b1;
                  if (tbl_countdown[s] == '0) begin
                     tbl_countdown[s] = tbl_interval[s];
                     post_run(s);
                  end
               end else if (!tbl_done[s]) begin
                  if (tbl_countdown[s] != '0) begin
                     tbl_countdown[s] = tbl_countdown[s] - 1'b1;
                  end else begin
                     post_run(s);
                     tbl_done[s] = 1'b1;
                  end
               end
            end
         end
         CMD_ADD: begin
            if (tbl_live < SLOTS) begin
               tbl_interval[tbl_live]  = intv;
               tbl_countdown[tbl_live] = intv;
               tbl_periodic[tbl_live]  = per;
               tbl_done[tbl_live]      = 1'b0;
               tbl_runs[tbl_live]      = '0;
               r.task_index            = task_index_type'(tbl_live);
               tbl_live++;
            end else begin
               r.status = ST_FULL;
            end
         end
         CMD_DISPATCH: begin
            r.status = ST_EMPTY;
            for (s = 0; s < tbl_live; s++) begin
               if (!found && tbl_runs[s] != '0) begin
                  tbl_runs[s]  = tbl_runs[s] - 1'b1;
                  r.status     = ST_OK;
                  r.task_index = task_index_type'(s);
                  r.dispatched = 1'b1;
                  found        = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         tbl_live = 0;
         owed_replies.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.status     = rsp_if.status;
            got.task_index = rsp_if.task_index;
            got.dispatched = rsp_if.dispatched;
            if (owed_replies.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected item: status %0d index %0d dispatched %0d",
                           got.status, got.task_index, got.dispatched);
               fail_count <= fail_count + 1;
            end else begin
               want = owed_replies.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp status %0d index %0d dispatched %0d, ",
                               "got status %0d index %0d dispatched %0d"},
                              want.status, want.task_index, want.dispatched,
                              got.status, got.task_index, got.dispatched);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            predict_reply(req_if.command, req_if.interval, req_if.periodic, want);
            owed_replies.push_back(want);
         end
         outstanding <= owed_replies.size();
      end
   end

endmodule

// ===== dv/tb_tick_task_scheduler.sv =====
module tb_tick_task_scheduler;
   timeunit 1ns;
   timeprecision 1ps;
   import tts_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;
   int   send_idle_pct = 12;
   int   recv_idle_pct = 58;
   logic hold_rsp      = 1'b0;
   logic hold_done     = 1'b0;

   tts_req_if req_if ();
   tts_rsp_if rsp_if ();

   tick_task_scheduler u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   tts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic send_item(input command_type cmd, input interval_type intv,
                            input logic per);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.command  <= cmd;
      req_if.interval <= intv;
      req_if.periodic <= per;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // receiver, with one long hold-off so the block backs up
   initial begin
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      int          n;
      int          r;
      command_type cmd;
      req_if.valid    = 1'b0;
      req_if.command  = CMD_TICK;
      req_if.interval = '0;
      req_if.periodic = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table
      send_item(CMD_DISPATCH, 16'h0000, 1'b0);
      send_item(CMD_TICK,     16'h0000, 1'b0);
      send_item(CMD_UNUSED,   16'hFFFF, 1'b1);
      // fill all slots
      send_item(CMD_ADD, 16'h0001, 1'b1);
      send_item(CMD_ADD, 16'h0000, 1'b0);
      send_item(CMD_ADD, 16'h0000, 1'b1);
      send_item(CMD_ADD, 16'h0003, 1'b0);
      send_item(CMD_ADD, 16'hFFFF, 1'b1);
      send_item(CMD_ADD, 16'hFFFF, 1'b0);
      send_item(CMD_ADD, 16'h0002, 1'b1);
      send_item(CMD_ADD, 16'h0001, 1'b0);
      // table full
      send_item(CMD_ADD, 16'hFFFF, 1'b1);
      send_item(CMD_ADD, 16'h0000, 1'b0);
      repeat (5) send_item(CMD_TICK, 16'h0000, 1'b0);
      repeat (7) send_item(CMD_DISPATCH, 16'h0000, 1'b0);
      send_item(CMD_UNUSED, 16'h0000, 1'b0);

      // tick-heavy stretches saturate the fastest slot's run counter, dispatch-heavy ones drain them
      for (n = 0; n < 1800; n++) begin
         if (n == 600) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
            while (outstanding != 0) @(posedge clock);
            send_idle_pct = 58;
            recv_idle_pct = 12;
         end
         if (n == 1200) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == 1250) hold_rsp = 1'b1;
         r = $urandom_range(99);
         if ((n % 900) < 300) begin
            if (r < 94)      cmd = CMD_TICK;
            else if (r < 98) cmd = CMD_DISPATCH;
            else if (r < 99) cmd = CMD_ADD;
            else             cmd = CMD_UNUSED;
         end else begin
            if (r < 5)       cmd = CMD_TICK;
            else if (r < 94) cmd = CMD_DISPATCH;
            else if (r < 97) cmd = CMD_ADD;
            else             cmd = CMD_UNUSED;
         end
         send_item(cmd, interval_type'($urandom()), 1'($urandom_range(1, 0)));
      end
      req_if.valid <= 1'b0;
      @(posedge clock);

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tts_pkg.sv
rtl/tts_req_if.sv
rtl/tts_rsp_if.sv
rtl/tick_task_scheduler.sv
dv/tts_checker.sv
dv/tb_tick_task_scheduler.sv
